@@ rtl/sts_pkg.sv @@
// Shared types, constants and helper functions for the script token scanner.
package sts_pkg;

	localparam int unsigned TOKEN_LEN_MAX_DEF = 255;
	localparam int unsigned KIND_W = 6;
	localparam int unsigned LINE_W = 16;
	localparam int unsigned COL_W  = 16;
	localparam int unsigned QUEUE_DEPTH = 4;

	typedef enum logic [6:0] {
		M_IDLE    = 7'b0000001,
		M_HELD    = 7'b0000010,
		M_NUM     = 7'b0000100,
		M_NUM_DOT = 7'b0001000,
		M_FRAC    = 7'b0010000,
		M_IDENT   = 7'b0100000,
		M_COMMENT = 7'b1000000
	} mode_t;

	typedef enum logic [2:0] {
		OP_NONE  = 3'd0,
		OP_BANG  = 3'd1,
		OP_EQ    = 3'd2,
		OP_LT    = 3'd3,
		OP_GT    = 3'd4,
		OP_SLASH = 3'd5
	} op_t;

	localparam logic [KIND_W-1:0] K_LPAREN = 6'd0;
	localparam logic [KIND_W-1:0] K_RPAREN = 6'd1;
	localparam logic [KIND_W-1:0] K_LBRACE = 6'd2;
	localparam logic [KIND_W-1:0] K_RBRACE = 6'd3;
	localparam logic [KIND_W-1:0] K_COMMA  = 6'd4;
	localparam logic [KIND_W-1:0] K_DOT    = 6'd5;
	localparam logic [KIND_W-1:0] K_MINUS  = 6'd6;
	localparam logic [KIND_W-1:0] K_PLUS   = 6'd7;
	localparam logic [KIND_W-1:0] K_SEMI   = 6'd8;
	localparam logic [KIND_W-1:0] K_SLASH  = 6'd9;
	localparam logic [KIND_W-1:0] K_STAR   = 6'd10;
	localparam logic [KIND_W-1:0] K_BANG   = 6'd11;
	localparam logic [KIND_W-1:0] K_EQUAL  = 6'd13;
	localparam logic [KIND_W-1:0] K_GREATER = 6'd15;
	localparam logic [KIND_W-1:0] K_LESS   = 6'd17;
	localparam logic [KIND_W-1:0] K_IDENT  = 6'd19;
	localparam logic [KIND_W-1:0] K_NUMBER = 6'd20;
	localparam logic [KIND_W-1:0] K_ERROR  = 6'd37;

	localparam int unsigned KW_COUNT = 16;
	localparam int unsigned KW_CHARS = 6;

	function automatic logic [8*KW_CHARS-1:0] kw_text(input logic [3:0] i);
		logic [8*KW_CHARS-1:0] w;
		case (i)
			4'd0:  w = 48'h00_00_00_64_6e_61;       // and
			4'd1:  w = 48'h00_73_73_61_6c_63;       // class
			4'd2:  w = 48'h00_00_65_73_6c_65;       // else
			4'd3:  w = 48'h00_65_73_6c_61_66;       // false
			4'd4:  w = 48'h00_00_00_6e_75_66;       // fun
			4'd5:  w = 48'h00_00_00_72_6f_66;       // for
			4'd6:  w = 48'h00_00_00_00_66_69;       // if
			4'd7:  w = 48'h00_00_00_6c_69_6e;       // nil
			4'd8:  w = 48'h00_00_00_00_72_6f;       // or
			4'd9:  w = 48'h00_74_6e_69_72_70;       // print
			4'd10: w = 48'h6e_72_75_74_65_72;       // return
			4'd11: w = 48'h00_72_65_70_75_73;       // super
			4'd12: w = 48'h00_00_73_69_68_74;       // this
			4'd13: w = 48'h00_00_65_75_72_74;       // true
			4'd14: w = 48'h00_00_00_72_61_76;       // var
			4'd15: w = 48'h00_65_6c_69_68_77;       // while
			default: w = '0;
		endcase
		return w;
	endfunction

	function automatic logic [2:0] kw_len(input logic [3:0] i);
		logic [2:0] n;
		case (i)
			4'd0, 4'd4, 4'd5, 4'd7, 4'd14: n = 3'd3;
			4'd6, 4'd8:                     n = 3'd2;
			4'd2, 4'd12, 4'd13:             n = 3'd4;
			4'd10:                          n = 3'd6;
			default:                        n = 3'd5;
		endcase
		return n;
	endfunction

	function automatic logic [KIND_W-1:0] single_op_kind(input op_t op);
		logic [KIND_W-1:0] k;
		case (op)
			OP_BANG: k = K_BANG;
			OP_EQ:   k = K_EQUAL;
			OP_GT:   k = K_GREATER;
			OP_LT:   k = K_LESS;
			default: k = K_SLASH;
		endcase
		return k;
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= 8'h30) && (c <= 8'h39);
	endfunction

	function automatic logic is_alpha(input logic [7:0] c);
		return ((c >= 8'h61) && (c <= 8'h7a)) || ((c >= 8'h41) && (c <= 8'h5a));
	endfunction

	function automatic logic [COL_W-1:0] inc_sat(input logic [COL_W-1:0] v);
		return (v == '1) ? v : v + 1'b1;
	endfunction

endpackage

@@ rtl/sts_stream_if.sv @@
// Valid/ready stream interface carrying one payload beat.
interface sts_stream_if #(parameter type payload_t = logic) (input logic clk);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/sts_types_pkg.sv @@
// Payload types of the scanner's channels and its internal queue.
package sts_types_pkg;
	import sts_pkg::*;

	typedef struct packed {
		logic [7:0] source_byte;
		logic       is_final;
	} in_beat_t;

	typedef struct packed {
		logic [KIND_W-1:0] token_kind;
		logic [7:0]        token_length;
		logic [LINE_W-1:0] line_number;
		logic [COL_W-1:0]  end_column;
		logic              last_in_run;
	} token_t;

	// one byte's worth of results: up to three tokens; a pending identifier is
	// resolved to its keyword in the back part
	typedef struct packed {
		logic [1:0]            count;
		token_t [2:0]          tok;
		logic [2:0]            needs_kw;
		logic [8*KW_CHARS-1:0] kw_buf;
		logic [7:0]            kw_len;
	} group_t;
endpackage

@@ rtl/script_token_scanner.sv @@
// Top level of the script token scanner.
// Usage:
//   in  : one beat per source byte (source_byte, is_final); the final byte of a
//         source flushes the pending token and returns the scanner to line 1,
//         column 0.
//   out : one beat per token (token_kind, token_length, line_number,
//         end_column, last_in_run). A byte causes zero to three tokens.
// Throughput: one byte per cycle while the output keeps up; the classifier
//   state (mode, length, line, column) is formed combinationally and registered
//   as each byte is taken. Output runs at one token per cycle while out.ready
//   is high, so a byte that causes two or three tokens keeps the output busy and
//   the group queue absorbs it.
// Path: a token is written to the group queue, then to the output register.
// Reset: arst_n clears the scanner state, empties the group queue and drops
//   any token not yet delivered.
// Stall: when out.ready is low, the output register holds, the queue fills
//   (QUEUE_DEPTH groups), and then in.ready falls until space frees.
module script_token_scanner #(
	parameter int unsigned TOKEN_LEN_MAX = sts_pkg::TOKEN_LEN_MAX_DEF,
	parameter int unsigned QUEUE_DEPTH   = sts_pkg::QUEUE_DEPTH
) (
	input  logic  clk,
	input  logic  arst_n,
	sts_stream_if.sink   in,
	sts_stream_if.source out
);
	import sts_types_pkg::*;

	logic   fv, fr, qv, qr;
	group_t fd, qd;
	token_t od;

	sts_front #(.TOKEN_LEN_MAX(TOKEN_LEN_MAX)) u_front (
		.clk, .arst_n,
		.in_valid(in.valid), .in_data(in.data), .in_ready(in.ready),
		.grp_valid(fv), .grp_data(fd), .grp_ready(fr)
	);

	sts_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk, .arst_n,
		.wr_valid(fv), .wr_data(fd), .wr_ready(fr),
		.rd_valid(qv), .rd_data(qd), .rd_ready(qr)
	);

	sts_back u_back (
		.clk, .arst_n,
		.grp_valid(qv), .grp_data(qd), .grp_ready(qr),
		.out_valid(out.valid), .out_data(od), .out_ready(out.ready)
	);

	assign out.data = od;
endmodule

@@ rtl/sts_front.sv @@
// Front part: consumes one byte per beat and forms the token group it causes.
module sts_front #(
	parameter int unsigned TOKEN_LEN_MAX = sts_pkg::TOKEN_LEN_MAX_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  sts_types_pkg::in_beat_t in_data,
	output logic                 in_ready,
	output logic                 grp_valid,
	output sts_types_pkg::group_t grp_data,
	input  logic                 grp_ready
);
	import sts_pkg::*;
	import sts_types_pkg::*;

	localparam int unsigned LW = 8;
	localparam logic [LW-1:0] LMAX = LW'(TOKEN_LEN_MAX > 255 ? 255 : TOKEN_LEN_MAX);

	mode_t                 mode_q, mode_d;
	op_t                   op_q, op_d;
	logic [8*KW_CHARS-1:0] kw_q, kw_d;
	logic [LW-1:0]         len_q, len_d;
	logic [LINE_W-1:0]     line_q, line_d;
	logic [COL_W-1:0]      col_q, col_d;
	logic [COL_W-1:0]      nend_q, nend_d;

	group_t g;
	logic   fire;
	logic [7:0] c;
	logic   fin, consumed;
	logic [COL_W-1:0] nxt;

	assign in_ready  = grp_ready;
	assign grp_valid = in_valid;
	assign fire      = in_valid && grp_ready;
	assign grp_data  = g;
	assign c   = in_data.source_byte;
	assign fin = in_data.is_final;
	assign nxt = inc_sat(col_q);

	function automatic logic [LW-1:0] ladd(input logic [LW-1:0] v, input logic [1:0] a);
		logic [LW:0] s;
		s = {1'b0, v} + {{(LW-1){1'b0}}, a};
		return (s > {1'b0, LMAX}) ? LMAX : s[LW-1:0];
	endfunction

	always_comb begin
		mode_t m;
		op_t   o;
		logic [KW_CHARS*8-1:0] kb;
		logic [LW-1:0] ln;
		logic [LINE_W-1:0] lc;
		logic [COL_W-1:0] cc;
		logic [COL_W-1:0] ne;
		logic [1:0] n;
		token_t [2:0] t;
		logic [2:0] nk;
		logic [KW_CHARS*8-1:0] kwe;
		logic [LW-1:0] lne;

		m = mode_q; o = op_q; kb = kw_q; ln = len_q; lc = line_q; cc = col_q; ne = nend_q;
		n = 2'd0; t = '0; nk = '0; consumed = 1'b1;

		case (mode_q)
			M_HELD: begin
				if (c == 8'h3d && op_q != OP_SLASH) begin
					cc = nxt;
					t[n] = '{single_op_kind(op_q) + 1'b1, 8'd2, lc, nxt, 1'b0}; n = n + 1'b1;
					m = M_IDLE; o = OP_NONE;
				end else if (c == 8'h2f && op_q == OP_SLASH) begin
					cc = nxt; m = M_COMMENT; o = OP_NONE;
				end else begin
					t[n] = '{single_op_kind(op_q), 8'd1, lc, col_q, 1'b0}; n = n + 1'b1;
					m = M_IDLE; o = OP_NONE; consumed = 1'b0;
				end
			end
			M_NUM: begin
				if (is_digit(c)) begin
					ln = ladd(ln, 2'd1); cc = nxt;
				end else if (c == 8'h2e) begin
					ne = col_q; cc = nxt; m = M_NUM_DOT;
				end else begin
					t[n] = '{K_NUMBER, ln, lc, col_q, 1'b0}; n = n + 1'b1;
					m = M_IDLE; consumed = 1'b0;
				end
			end
			M_NUM_DOT: begin
				if (is_digit(c)) begin
					ln = ladd(ln, 2'd2); cc = nxt; m = M_FRAC;
				end else begin
					t[n] = '{K_NUMBER, ln, lc, nend_q, 1'b0}; n = n + 1'b1;
					t[n] = '{K_DOT, 8'd1, lc, col_q, 1'b0}; n = n + 1'b1;
					m = M_IDLE; consumed = 1'b0;
				end
			end
			M_FRAC: begin
				if (is_digit(c)) begin
					ln = ladd(ln, 2'd1); cc = nxt;
				end else begin
					t[n] = '{K_NUMBER, ln, lc, col_q, 1'b0}; n = n + 1'b1;
					m = M_IDLE; consumed = 1'b0;
				end
			end
			M_IDENT: begin
				if (is_digit(c) || is_alpha(c)) begin
					for (int i = 0; i < KW_CHARS; i++)
						if (ln == LW'(i)) kb[8*i +: 8] = c;
					ln = ladd(ln, 2'd1); cc = nxt;
				end else begin
					t[n] = '{K_IDENT, ln, lc, col_q, 1'b0}; nk[n] = 1'b1; n = n + 1'b1;
					m = M_IDLE; consumed = 1'b0;
				end
			end
			M_COMMENT: begin
				if (c == 8'h0a) begin
					m = M_IDLE; consumed = 1'b0;
				end else begin
					cc = nxt;
				end
			end
			default: begin
				m = M_IDLE; consumed = 1'b0;
			end
		endcase

		if (!consumed) begin
			if (c == 8'h0a) begin
				lc = inc_sat(lc); cc = '0;
			end else begin
				cc = inc_sat(cc);
				case (c)
					8'h28: begin t[n] = '{K_LPAREN, 8'd1, lc, cc, 1'b0}; n = n + 1'b1; end
					8'h29: begin t[n] = '{K_RPAREN, 8'd1, lc, cc, 1'b0}; n = n + 1'b1; end
					8'h7b: begin t[n] = '{K_LBRACE, 8'd1, lc, cc, 1'b0}; n = n + 1'b1; end
					8'h7d: begin t[n] = '{K_RBRACE, 8'd1, lc, cc, 1'b0}; n = n + 1'b1; end
					8'h2c: begin t[n] = '{K_COMMA, 8'd1, lc, cc, 1'b0}; n = n + 1'b1; end
					8'h2e: begin t[n] = '{K_DOT, 8'd1, lc, cc, 1'b0}; n = n + 1'b1; end
					8'h2d: begin t[n] = '{K_MINUS, 8'd1, lc, cc, 1'b0}; n = n + 1'b1; end
					8'h2b: begin t[n] = '{K_PLUS, 8'd1, lc, cc, 1'b0}; n = n + 1'b1; end
					8'h3b: begin t[n] = '{K_SEMI, 8'd1, lc, cc, 1'b0}; n = n + 1'b1; end
					8'h2a: begin t[n] = '{K_STAR, 8'd1, lc, cc, 1'b0}; n = n + 1'b1; end
					8'h21: begin m = M_HELD; o = OP_BANG; end
					8'h3d: begin m = M_HELD; o = OP_EQ; end
					8'h3c: begin m = M_HELD; o = OP_LT; end
					8'h3e: begin m = M_HELD; o = OP_GT; end
					8'h2f: begin m = M_HELD; o = OP_SLASH; end
					8'h20, 8'h0d, 8'h09: ;
					default: begin
						if (is_digit(c)) begin
							m = M_NUM; ln = LW'(1);
						end else if (is_alpha(c)) begin
							m = M_IDENT; ln = LW'(1); kb = {{(8*KW_CHARS-8){1'b0}}, c};
						end else begin
							t[n] = '{K_ERROR, 8'd1, lc, cc, 1'b0}; n = n + 1'b1;
						end
					end
				endcase
			end
		end

		// identifier text as it stands when the token is closed
		kwe = kb;
		lne = ln;

		if (fin) begin
			case (m)
				M_HELD: begin t[n] = '{single_op_kind(o), 8'd1, lc, cc, 1'b0}; n = n + 1'b1; end
				M_NUM, M_FRAC: begin t[n] = '{K_NUMBER, ln, lc, cc, 1'b0}; n = n + 1'b1; end
				M_NUM_DOT: begin
					t[n] = '{K_NUMBER, ln, lc, ne, 1'b0}; n = n + 1'b1;
					t[n] = '{K_DOT, 8'd1, lc, cc, 1'b0}; n = n + 1'b1;
				end
				M_IDENT: begin t[n] = '{K_IDENT, ln, lc, cc, 1'b0}; nk[n] = 1'b1; n = n + 1'b1; end
				default: ;
			endcase
			m = M_IDLE; o = OP_NONE; kb = '0; ln = '0; lc = LINE_W'(1); cc = '0; ne = '0;
		end

		if (n != 2'd0) t[n - 1'b1].last_in_run = 1'b1;

		g.count    = n;
		g.tok      = t;
		g.needs_kw = nk;
		g.kw_buf   = kwe;
		g.kw_len   = lne;
		mode_d = m; op_d = o; kw_d = kb; len_d = ln; line_d = lc; col_d = cc; nend_d = ne;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_IDLE;
			op_q   <= OP_NONE;
			kw_q   <= '0;
			len_q  <= '0;
			line_q <= LINE_W'(1);
			col_q  <= '0;
			nend_q <= '0;
		end else if (fire) begin
			mode_q <= mode_d;
			op_q   <= op_d;
			kw_q   <= kw_d;
			len_q  <= len_d;
			line_q <= line_d;
			col_q  <= col_d;
			nend_q <= nend_d;
		end
	end
endmodule

@@ rtl/sts_queue.sv @@
// Short queue of token groups between the front and back parts.
module sts_queue #(
	parameter int unsigned DEPTH = sts_pkg::QUEUE_DEPTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_valid,
	input  sts_types_pkg::group_t wr_data,
	output logic                  wr_ready,
	output logic                  rd_valid,
	output sts_types_pkg::group_t rd_data,
	input  logic                  rd_ready
);
	import sts_types_pkg::*;

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	group_t        mem_q [DEPTH];
	logic [AW-1:0] wp_q, rp_q;
	logic [AW:0]   cnt_q;
	logic          push, pop;

	assign wr_ready = (cnt_q != (AW+1)'(DEPTH));
	assign rd_valid = (cnt_q != '0);
	assign rd_data  = mem_q[rp_q];
	assign push = wr_valid && wr_ready;
	assign pop  = rd_valid && rd_ready;

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= (wp_q == AW'(DEPTH-1)) ? '0 : wp_q + 1'b1;
			if (pop)  rp_q <= (rp_q == AW'(DEPTH-1)) ? '0 : rp_q + 1'b1;
			cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(pop);
		end
	end
endmodule

@@ rtl/sts_back.sv @@
// Back part: resolves keywords and serialises a group's tokens, one per beat.
module sts_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  grp_valid,
	input  sts_types_pkg::group_t grp_data,
	output logic                  grp_ready,
	output logic                  out_valid,
	output sts_types_pkg::token_t out_data,
	input  logic                  out_ready
);
	import sts_pkg::*;
	import sts_types_pkg::*;

	logic [1:0]        idx_q;
	logic              empty_grp, last_tok, take;
	token_t            cur;
	logic [KIND_W-1:0] kw_kind;

	// output register
	logic   ov_q;
	token_t od_q;

	always_comb begin
		kw_kind = K_IDENT;
		for (int i = 0; i < KW_COUNT; i++)
			if (grp_data.kw_len == 8'(kw_len(4'(i))) && grp_data.kw_buf == kw_text(4'(i)))
				kw_kind = KIND_W'(21 + i);
	end

	assign empty_grp = (grp_data.count == 2'd0);
	assign last_tok  = (idx_q + 1'b1 >= grp_data.count);
	assign take      = grp_valid && !empty_grp && (!ov_q || out_ready);
	assign grp_ready = empty_grp || (take && last_tok);

	always_comb begin
		cur = grp_data.tok[idx_q];
		if (grp_data.needs_kw[idx_q]) cur.token_kind = kw_kind;
	end

	assign out_valid = ov_q;
	assign out_data  = od_q;

	always_ff @(posedge clk) begin
		if (take) od_q <= cur;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q  <= 1'b0;
			idx_q <= '0;
		end else begin
			if (take) ov_q <= 1'b1;
			else if (out_ready) ov_q <= 1'b0;
			if (take) idx_q <= last_tok ? 2'd0 : idx_q + 1'b1;
		end
	end
endmodule

@@ rtl/sts_checker.sv @@
// Port-level checker for the script token scanner and its bind.
module sts_checker (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   out_valid,
	input logic                   out_ready,
	input sts_types_pkg::token_t  out_data
);
	import sts_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("output beat changed while stalled");

	a_line_pos: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.line_number != '0)
		else $error("token on line zero");

	a_kind_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.token_kind <= K_ERROR)
		else $error("token kind out of range");

	a_len_pos: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.token_length != '0)
		else $error("empty token");
endmodule

bind script_token_scanner sts_checker u_sts_checker (
	.clk(clk), .arst_n(arst_n),
	.out_valid(out.valid), .out_ready(out.ready), .out_data(out.data)
);
